FILE: hw/rtl/sliding_window_mode_filter_assert.svh
// ----------------------------------------------------------------------------
// Sliding window mode filter assertion macros
// Concurrent assertion wrappers clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MODE_FILTER_ASSERT_SVH
`define SLIDING_WINDOW_MODE_FILTER_ASSERT_SVH

// property must hold at every edge out of reset
`define SWMF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("swmf assertion failed");

// expression must never be true out of reset
`define SWMF_ASSERT_NEVER(lbl, expr) \
  `SWMF_ASSERT(lbl, !(expr))

`endif

FILE: hw/rtl/swmf_pkg.sv
// ----------------------------------------------------------------------------
// Sliding window mode filter package
// Fixed register widths, reset values and the tally control word.
// ----------------------------------------------------------------------------
`default_nettype none

package swmf_pkg;

  localparam int unsigned CFG_W        = 5;
  localparam logic [CFG_W-1:0] LEN_RESET = 5'd8;
  localparam int unsigned NEW_COUNT_W  = 8;

  typedef struct packed {
    logic clear_best;
    logic clear_freq;
    logic count;
    logic commit;
  } tally_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/sliding_window_mode_filter.sv
// Flow: no new word is taken until the last result is handed to the output;
// the busy period is set by the match scan, one compare per cycle on the shared
// tally unit fed by the store's second read port.
// Reset: window length 8, fill 0; the count store is not cleared.
// ----------------------------------------------------------------------------
// Sliding window mode filter
// Keeps the most recent counts and returns the most frequent one with the fill.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sliding_window_mode_filter_assert.svh"

module sliding_window_mode_filter import swmf_pkg::*; #(
  parameter int unsigned WINDOW_MAX = 16,
  parameter int unsigned COUNT_BITS = 8,
  localparam int unsigned FILL_W    = $clog2(WINDOW_MAX + 1),
  localparam int unsigned OUT_W     = ((COUNT_BITS + 2 * FILL_W + 7) / 8) * 8
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_W-1:0]       cfg_wdata_i,      // window_length
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [NEW_COUNT_W-1:0] s_axis_tdata,     // [7:0] new_count
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic      [OUT_W-1:0]       m_axis_tdata      // mode_value, mode_frequency,
                                                        // window_fill, zero pad
);

  localparam int unsigned PTR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned CMP_W = ((FILL_W > CFG_W) ? FILL_W : CFG_W) + 1;
  localparam int unsigned SAT_W = (COUNT_BITS > NEW_COUNT_W) ? COUNT_BITS : NEW_COUNT_W;
  localparam logic [SAT_W-1:0] CMAX = SAT_W'((64'd1 << COUNT_BITS) - 64'd1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_MAX - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ISSUE  = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_COMMIT = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]            state_q, state_d;
  logic [CFG_W-1:0]      len_q;
  logic [FILL_W-1:0]     fill_q, fill_d;
  logic [PTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]      newest_q, newest_d;
  logic [PTR_W-1:0]      ptr_i_q, ptr_i_d;
  logic [PTR_W-1:0]      ptr_j_q, ptr_j_d;
  logic [FILL_W-1:0]     i_cnt_q, i_cnt_d;
  logic [FILL_W-1:0]     j_cnt_q, j_cnt_d;
  logic                  out_valid_q, out_valid_d;
  logic [COUNT_BITS-1:0] out_val_q, out_val_d;
  logic [FILL_W-1:0]     out_freq_q, out_freq_d;
  logic [FILL_W-1:0]     out_fill_q, out_fill_d;

  logic                  in_acc;
  logic [SAT_W-1:0]      v_ext;
  logic [COUNT_BITS-1:0] v_sat;
  logic [CMP_W-1:0]      len_ext, eff_len, fill_inc, new_fill;
  logic                  we;
  logic [PTR_W-1:0]      raddr_b;
  logic [COUNT_BITS-1:0] rdata_a, rdata_b;
  tally_ctrl_t           tctrl;
  logic [COUNT_BITS-1:0] best_val;
  logic [FILL_W-1:0]     best_freq;

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    r = (p == '0) ? PTR_LAST : p - PTR_W'(1);
    return r;
  endfunction

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign v_ext = SAT_W'(s_axis_tdata);
  assign v_sat = (v_ext > CMAX) ? CMAX[COUNT_BITS-1:0] : v_ext[COUNT_BITS-1:0];

  assign len_ext  = CMP_W'(len_q);
  assign eff_len  = (len_ext == '0) ? CMP_W'(1) :
                    ((len_ext > CMP_W'(WINDOW_MAX)) ? CMP_W'(WINDOW_MAX) : len_ext);
  assign fill_inc = CMP_W'(fill_q) + CMP_W'(1);
  assign new_fill = (fill_inc > eff_len) ? eff_len : fill_inc;

  assign we      = in_acc;
  assign raddr_b = (state_q == S_ISSUE) ? newest_q : ptr_j_q;

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    wr_ptr_d    = wr_ptr_q;
    newest_d    = newest_q;
    ptr_i_d     = ptr_i_q;
    ptr_j_d     = ptr_j_q;
    i_cnt_d     = i_cnt_q;
    j_cnt_d     = j_cnt_q;
    out_valid_d = out_valid_q;
    out_val_d   = out_val_q;
    out_freq_d  = out_freq_q;
    out_fill_d  = out_fill_q;
    tctrl       = '0;

    if (m_axis_tvalid && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          tctrl.clear_best = 1'b1;
          fill_d   = FILL_W'(new_fill);
          newest_d = wr_ptr_q;
          ptr_i_d  = wr_ptr_q;
          wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
          i_cnt_d  = '0;
          state_d  = S_ISSUE;
        end
      end
      S_ISSUE: begin
        tctrl.clear_freq = 1'b1;
        ptr_j_d = ptr_dec(newest_q);
        j_cnt_d = FILL_W'(1);
        state_d = S_SCAN;
      end
      S_SCAN: begin
        tctrl.count = 1'b1;
        if (j_cnt_q == fill_q) begin
          state_d = S_COMMIT;
        end else begin
          ptr_j_d = ptr_dec(ptr_j_q);
          j_cnt_d = j_cnt_q + FILL_W'(1);
        end
      end
      S_COMMIT: begin
        tctrl.commit = 1'b1;
        ptr_i_d = ptr_dec(ptr_i_q);
        i_cnt_d = i_cnt_q + FILL_W'(1);
        state_d = ((i_cnt_q + FILL_W'(1)) == fill_q) ? S_DONE : S_ISSUE;
      end
      S_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_val_d   = best_val;
          out_freq_d  = best_freq;
          out_fill_d  = fill_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= LEN_RESET;
      fill_q      <= '0;
      wr_ptr_q    <= '0;
      newest_q    <= '0;
      ptr_i_q     <= '0;
      ptr_j_q     <= '0;
      i_cnt_q     <= '0;
      j_cnt_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        len_q <= cfg_wdata_i;
      end
      fill_q      <= fill_d;
      wr_ptr_q    <= wr_ptr_d;
      newest_q    <= newest_d;
      ptr_i_q     <= ptr_i_d;
      ptr_j_q     <= ptr_j_d;
      i_cnt_q     <= i_cnt_d;
      j_cnt_q     <= j_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_val_q  <= out_val_d;
    out_freq_q <= out_freq_d;
    out_fill_q <= out_fill_d;
  end

  swmf_window_ram #(
    .DEPTH (WINDOW_MAX),
    .WIDTH (COUNT_BITS),
    .AW    (PTR_W)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (wr_ptr_q),
    .wdata_i   (v_sat),
    .raddr_a_i (ptr_i_q),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  swmf_tally #(
    .COUNT_BITS (COUNT_BITS),
    .FILL_W     (FILL_W)
  ) u_tally (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (tctrl),
    .cand_i      (rdata_a),
    .probe_i     (rdata_b),
    .best_val_o  (best_val),
    .best_freq_o (best_freq)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'({out_fill_q, out_freq_q, out_val_q});

  `SWMF_ASSERT(a_busy_after_accept, in_acc |=> !s_axis_tready)
  `SWMF_ASSERT_NEVER(a_fill_over_max, fill_q > FILL_W'(WINDOW_MAX))
  `SWMF_ASSERT(a_freq_in_fill, out_valid_q |-> (out_freq_q != '0 && out_freq_q <= out_fill_q))
  `SWMF_ASSERT_NEVER(a_scan_past_fill, (state_q == S_SCAN) && (j_cnt_q > fill_q))

endmodule

`default_nettype wire

FILE: hw/rtl/swmf_window_ram.sv
// ----------------------------------------------------------------------------
// Sliding window mode filter count store
// One write port and two registered read ports over the circular window.
// ----------------------------------------------------------------------------
`default_nettype none

module swmf_window_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 8,
  parameter int unsigned AW    = 4
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_a_i,
  input  wire logic [AW-1:0]    raddr_b_i,
  output logic      [WIDTH-1:0] rdata_a_o,
  output logic      [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/swmf_tally.sv
// ----------------------------------------------------------------------------
// Sliding window mode filter tally unit
// Shared compare unit: counts matches of a candidate and keeps the best one.
// ----------------------------------------------------------------------------
`default_nettype none

module swmf_tally import swmf_pkg::*; #(
  parameter int unsigned COUNT_BITS = 8,
  parameter int unsigned FILL_W     = 5
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire tally_ctrl_t           ctrl_i,
  input  wire logic [COUNT_BITS-1:0] cand_i,
  input  wire logic [COUNT_BITS-1:0] probe_i,
  output logic      [COUNT_BITS-1:0] best_val_o,
  output logic      [FILL_W-1:0]     best_freq_o
);

  logic [FILL_W-1:0]     freq_q, freq_d;
  logic [COUNT_BITS-1:0] best_val_q, best_val_d;
  logic [FILL_W-1:0]     best_freq_q, best_freq_d;
  logic                  better;

  assign better = (freq_q > best_freq_q) ||
                  ((freq_q == best_freq_q) && (cand_i < best_val_q));

  always_comb begin
    freq_d      = freq_q;
    best_val_d  = best_val_q;
    best_freq_d = best_freq_q;
    if (ctrl_i.clear_freq) begin
      freq_d = '0;
    end else if (ctrl_i.count && (cand_i == probe_i)) begin
      freq_d = freq_q + FILL_W'(1);
    end
    if (ctrl_i.clear_best) begin
      best_val_d  = '0;
      best_freq_d = '0;
    end else if (ctrl_i.commit && better) begin
      best_val_d  = cand_i;
      best_freq_d = freq_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q      <= '0;
      best_freq_q <= '0;
    end else begin
      freq_q      <= freq_d;
      best_freq_q <= best_freq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_val_q <= best_val_d;
  end

  assign best_val_o  = best_val_q;
  assign best_freq_o = best_freq_q;

endmodule

`default_nettype wire
